// ----- rtl/fade_envelope_slot_engine_assert.svh -----
// Assertion macros for the fade envelope slot engine.
// Included by the top level; uses only clock and reset from the includer.
`ifndef FADE_ENVELOPE_SLOT_ENGINE_ASSERT_SVH
`define FADE_ENVELOPE_SLOT_ENGINE_ASSERT_SVH
// implication checked every clock outside reset
`define FES_ASSERT_IMP(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("fes check failed");
// implication checked in the next clock
`define FES_ASSERT_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("fes check failed");
`endif

// ----- rtl/fes_pkg.sv -----
// Package for the fade envelope slot engine: word types, codes, constants.
// No dependencies.
`timescale 1ns / 1ps
package fes_pkg;
   localparam int SLOTS = 8;
   localparam int SLOT_W = $clog2(SLOTS);
   localparam int CNT_W = $clog2(SLOTS + 1);
   localparam logic [17:0] LIFE_MAX = 18'h3FFFF;

   localparam logic CMD_ADD = 1'b0;
   localparam logic CMD_TICK = 1'b1;
   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_DUP = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;
   localparam logic REG_MERGE = 1'b0;
   localparam logic REG_HOLD = 1'b1;

   typedef struct packed {
      logic        cmd;
      logic [15:0] pos_x;
      logic [15:0] pos_y;
      logic [15:0] pos_z;
      logic [15:0] fade_in;
      logic [15:0] fade_out;
      logic [15:0] hold_time;
      logic [15:0] radius;
      logic [3:0]  fx_kind;
      logic [15:0] elapsed;
   } req_word_type;

   typedef struct packed {
      logic        report_kind;
      logic [1:0]  status;
      logic [2:0]  slot;
      logic [15:0] out_x;
      logic [15:0] out_y;
      logic [15:0] out_z;
      logic [7:0]  strength;
      logic [11:0] radius_whole;
      logic [3:0]  out_kind;
      logic        live;
      logic [3:0]  live_count;
      logic        last;
   } rsp_word_type;

   // controller to datapath commands
   typedef struct packed {
      logic              load;      // capture request word
      logic              clr_acc;   // clear dup/free/count scan flags
      logic              scan;      // add: check slot idx
      logic              commit;    // add: write slot and emit status
      logic              env;       // tick: compute life and phase
      logic              div_start; // tick: launch ramp division
      logic              upd;       // tick: store result, emit report
      logic [SLOT_W-1:0] idx;
   } ctl_type;

   // datapath status to controller
   typedef struct packed {
      logic cmd;
      logic need_div;
      logic div_done;
   } sts_type;
endpackage

// ----- rtl/fes_divider.sv -----
// Restoring divider for ramp factors: 26-bit numerator by 16-bit divisor.
// Uses fes_pkg; one quotient bit per clock.
`timescale 1ns / 1ps
module fes_divider
   import fes_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [25:0] num,
   input  logic [15:0] den,
   output logic        done,
   output logic [25:0] quo
);
   logic [25:0] q_ff, q_in;
   logic [16:0] r_ff, r_in;
   logic [15:0] d_ff, d_in;
   logic [4:0]  n_ff, n_in;
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [16:0] trial;

   // shift one numerator bit in, subtract when it fits
   always_comb begin
      q_in = q_ff; r_in = r_ff; d_in = d_ff; n_in = n_ff;
      busy_in = busy_ff; done_in = 1'b0;
      trial = {r_ff[15:0], q_ff[25]};
      if (start) begin
         q_in = num; r_in = '0; d_in = den; n_in = 5'd0; busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, d_ff}) begin
            r_in = trial - {1'b0, d_ff};
            q_in = {q_ff[24:0], 1'b1};
         end else begin
            r_in = trial;
            q_in = {q_ff[24:0], 1'b0};
         end
         n_in = n_ff + 5'd1;
         if (n_ff == 5'd25) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in;
      end
      q_ff <= q_in; r_ff <= r_in; d_ff <= d_in; n_ff <= n_in;
   end

   assign done = done_ff;
   assign quo = q_ff;
endmodule

// ----- rtl/fes_datapath.sv -----
// Datapath of the fade envelope slot engine: slot table, distance check,
// envelope and response word. Uses fes_pkg and fes_divider.
`timescale 1ns / 1ps
module fes_datapath
   import fes_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  ctl_type      ctl,
   output sts_type      sts,
   input  req_word_type req_word,
   input  logic         csr_we,
   input  logic [0:0]   csr_index,
   input  logic [31:0]  csr_wdata,
   output logic         rsp_strobe,
   output rsp_word_type rsp_word,
   output logic         engine_on
);
   logic [31:0] merge_ff;
   logic [7:0]  hold_ff;
   req_word_type req_ff;
   logic [SLOTS-1:0] valid_ff, valid_in;
   logic [15:0] sx_ff [SLOTS], sy_ff [SLOTS], sz_ff [SLOTS], srad_ff [SLOTS];
   logic [15:0] sfi_ff [SLOTS], shold_ff [SLOTS], sfo_ff [SLOTS];
   logic [3:0]  skind_ff [SLOTS];
   logic [17:0] slife_ff [SLOTS];
   logic        dup_ff, dup_in, free_ok_ff, free_ok_in, engine_ff, engine_in;
   logic [SLOT_W-1:0] free_ff, free_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [17:0] life_ff;
   logic [1:0]  phase_ff;   // 0 ramp up, 1 hold, 2 ramp down, 3 expired
   logic [25:0] div_num;
   logic [15:0] div_den;
   logic        div_done;
   logic [25:0] quo;
   rsp_word_type rsp_ff, rsp_in;
   logic        strobe_ff, strobe_in;

   // distance terms for the scanned slot
   logic signed [16:0] dx, dy, dz;
   logic [33:0] d2x, d2y, d2z;
   logic [35:0] dist_sq;
   logic [18:0] life_sum;
   logic [17:0] life_new, t1, t2;
   logic [7:0]  ramp_f;
   always_comb begin
      dx = 17'(signed'(sx_ff[ctl.idx])) - 17'(signed'(req_ff.pos_x));
      dy = 17'(signed'(sy_ff[ctl.idx])) - 17'(signed'(req_ff.pos_y));
      dz = 17'(signed'(sz_ff[ctl.idx])) - 17'(signed'(req_ff.pos_z));
      d2x = 34'(dx * dx);
      d2y = 34'(dy * dy);
      d2z = 34'(dz * dz);
      dist_sq = 36'(d2x) + 36'(d2y) + 36'(d2z);
      life_sum = 19'(slife_ff[ctl.idx]) + 19'(req_ff.elapsed);
      life_new = life_sum[18] ? LIFE_MAX : life_sum[17:0];
      t1 = 18'(sfi_ff[ctl.idx]) + 18'(shold_ff[ctl.idx]);
      t2 = t1 + 18'(sfo_ff[ctl.idx]);
      if (phase_ff == 2'd0) begin
         div_num = {life_ff, 8'd0};
         div_den = sfi_ff[ctl.idx];
      end else begin
         div_num = {18'(t2 - life_ff), 8'd0};
         div_den = sfo_ff[ctl.idx];
      end
      ramp_f = (quo > 26'(hold_ff)) ? hold_ff : quo[7:0];
   end

   fes_divider u_div (
      .clock(clock), .reset(reset), .start(ctl.div_start),
      .num(div_num), .den(div_den), .done(div_done), .quo(quo)
   );

   // only a live slot ever asks for a ramp division
   assign sts.cmd = req_ff.cmd;
   assign sts.need_div = valid_ff[ctl.idx] &&
                         ((phase_ff == 2'd0 && sfi_ff[ctl.idx] != 16'd0) || phase_ff == 2'd2);
   assign sts.div_done = div_done;

   // scan flags, valid bits and response
   always_comb begin
      dup_in = dup_ff; free_ok_in = free_ok_ff; free_in = free_ff;
      count_in = count_ff; valid_in = valid_ff; engine_in = engine_ff;
      rsp_in = '0; strobe_in = 1'b0;
      if (ctl.clr_acc) begin
         dup_in = 1'b0; free_ok_in = 1'b0; free_in = '0; count_in = '0;
      end
      if (ctl.scan) begin
         if (valid_ff[ctl.idx]) begin
            if (dist_sq < 36'(merge_ff) && srad_ff[ctl.idx] >= req_ff.radius) dup_in = 1'b1;
         end else if (!free_ok_ff) begin
            free_ok_in = 1'b1; free_in = ctl.idx;
         end
      end
      if (ctl.commit) begin
         strobe_in = 1'b1;
         rsp_in.last = 1'b1;
         if (dup_ff) rsp_in.status = ST_DUP;
         else if (!free_ok_ff) rsp_in.status = ST_FULL;
         else begin
            rsp_in.status = ST_OK;
            rsp_in.slot = 3'(free_ff);
            valid_in[free_ff] = 1'b1;
            engine_in = 1'b1;
         end
      end
      if (ctl.upd) begin
         strobe_in = 1'b1;
         rsp_in.report_kind = 1'b1;
         rsp_in.slot = 3'(ctl.idx);
         if (valid_ff[ctl.idx]) begin
            if (phase_ff == 2'd3) valid_in[ctl.idx] = 1'b0;
            else begin
               count_in = count_ff + CNT_W'(1);
               rsp_in.out_x = sx_ff[ctl.idx];
               rsp_in.out_y = sy_ff[ctl.idx];
               rsp_in.out_z = sz_ff[ctl.idx];
               rsp_in.radius_whole = srad_ff[ctl.idx][15:4];
               rsp_in.out_kind = skind_ff[ctl.idx];
               rsp_in.live = 1'b1;
               if (phase_ff == 2'd1) rsp_in.strength = hold_ff;
               else if (sts.need_div) rsp_in.strength = ramp_f;
               else rsp_in.strength = 8'd0;
            end
         end
         if (ctl.idx == '0) begin
            rsp_in.last = 1'b1;
            rsp_in.live_count = 4'(count_in);
            if (count_in == '0) engine_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         merge_ff <= 32'd1024; hold_ff <= 8'd253;
         valid_ff <= '0; engine_ff <= 1'b0; strobe_ff <= 1'b0;
      end else begin
         if (csr_we && csr_index == REG_MERGE) merge_ff <= csr_wdata;
         if (csr_we && csr_index == REG_HOLD) hold_ff <= csr_wdata[7:0];
         valid_ff <= valid_in; engine_ff <= engine_in; strobe_ff <= strobe_in;
      end
      dup_ff <= dup_in; free_ok_ff <= free_ok_in; free_ff <= free_in;
      count_ff <= count_in; rsp_ff <= rsp_in;
      if (ctl.load) req_ff <= req_word;
      // store new slot
      if (ctl.commit && !dup_ff && free_ok_ff) begin
         sx_ff[free_ff] <= req_ff.pos_x; sy_ff[free_ff] <= req_ff.pos_y;
         sz_ff[free_ff] <= req_ff.pos_z; srad_ff[free_ff] <= req_ff.radius;
         sfi_ff[free_ff] <= req_ff.fade_in; sfo_ff[free_ff] <= req_ff.fade_out;
         shold_ff[free_ff] <= req_ff.hold_time; skind_ff[free_ff] <= req_ff.fx_kind;
         slife_ff[free_ff] <= '0;
      end
      // advance life and classify phase
      if (ctl.env) begin
         life_ff <= life_new;
         slife_ff[ctl.idx] <= life_new;
         if (life_new <= 18'(sfi_ff[ctl.idx])) phase_ff <= 2'd0;
         else if (life_new <= t1) phase_ff <= 2'd1;
         else if (life_new < t2) phase_ff <= 2'd2;
         else phase_ff <= 2'd3;
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_word = rsp_ff;
   assign engine_on = engine_ff;
endmodule

// ----- rtl/fes_control.sv -----
// Controller of the fade envelope slot engine: walks slots for add and tick.
// Uses fes_pkg; drives the datapath through ctl_type.
`timescale 1ns / 1ps
module fes_control
   import fes_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  sts_type sts,
   output ctl_type ctl,
   output logic    busy
);
   typedef enum logic [2:0] {
      S_IDLE, S_DISPATCH, S_SCAN, S_COMMIT, S_ENV, S_DIV_GO, S_DIV_WAIT, S_UPD
   } state_type;
   state_type state_ff;
   logic [SLOT_W-1:0] idx_ff;

   always_comb begin
      ctl = '0;
      ctl.idx = idx_ff;
      case (state_ff)
         S_IDLE:     ctl.load = start;
         S_DISPATCH: ctl.clr_acc = 1'b1;
         S_SCAN:     ctl.scan = 1'b1;
         S_COMMIT:   ctl.commit = 1'b1;
         S_ENV:      ctl.env = 1'b1;
         S_DIV_GO:   ctl.div_start = sts.need_div;
         S_UPD:      ctl.upd = 1'b1;
         default:    ctl.load = 1'b0;
      endcase
   end

   assign busy = (state_ff != S_IDLE);

   // sequence: add scans upward, tick walks downward
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; idx_ff <= '0;
      end else begin
         case (state_ff)
            S_IDLE: if (start) state_ff <= S_DISPATCH;
            S_DISPATCH: begin
               if (sts.cmd == CMD_ADD) begin
                  idx_ff <= '0; state_ff <= S_SCAN;
               end else begin
                  idx_ff <= SLOT_W'(SLOTS - 1); state_ff <= S_ENV;
               end
            end
            S_SCAN: begin
               if (idx_ff == SLOT_W'(SLOTS - 1)) state_ff <= S_COMMIT;
               else idx_ff <= idx_ff + SLOT_W'(1);
            end
            S_COMMIT: state_ff <= S_IDLE;
            S_ENV: state_ff <= S_DIV_GO;
            S_DIV_GO: state_ff <= sts.need_div ? S_DIV_WAIT : S_UPD;
            S_DIV_WAIT: if (sts.div_done) state_ff <= S_UPD;
            S_UPD: begin
               if (idx_ff == '0) state_ff <= S_IDLE;
               else begin
                  idx_ff <= idx_ff - SLOT_W'(1); state_ff <= S_ENV;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

// ----- rtl/fade_envelope_slot_engine.sv -----
// Fade envelope slot engine: an 8-slot effect table with fade envelopes.
// An add keeps busy high while it checks one slot per cycle, and returns one
// status word in the cycle after. A tick runs the one-bit-per-cycle ramp
// divider for each live slot that ramps, and returns one word per slot from the
// highest index down, live count on the last. Results appear one cycle each
// on rsp_strobe and cannot be stalled; start is taken only while busy is low.
`timescale 1ns / 1ps
`include "fade_envelope_slot_engine_assert.svh"
module fade_envelope_slot_engine
   import fes_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_word_type req_word,
   input  logic         csr_we,
   input  logic [0:0]   csr_index,
   input  logic [31:0]  csr_wdata,
   output logic         rsp_strobe,
   output rsp_word_type rsp_word
);
   ctl_type ctl;
   sts_type sts;
   logic    engine_on;

   fes_control u_ctl (
      .clock(clock), .reset(reset), .start(start), .sts(sts), .ctl(ctl), .busy(busy)
   );

   fes_datapath u_dp (
      .clock(clock), .reset(reset), .ctl(ctl), .sts(sts), .req_word(req_word),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .rsp_strobe(rsp_strobe), .rsp_word(rsp_word), .engine_on(engine_on)
   );

   // a last tick word with nothing live leaves the engine off
   `FES_ASSERT_NEXT(a_engine_off, ctl.upd && ctl.idx == '0 && u_dp.count_in == '0, !engine_on)
   // add status words are always final
   `FES_ASSERT_IMP(a_add_last, rsp_strobe && !rsp_word.report_kind, rsp_word.last)
   // an accepted word makes the block busy
   `FES_ASSERT_NEXT(a_load_busy, start && !busy, busy)
endmodule

// ----- tb/tb_fade_envelope_slot_engine.sv -----
// Testbench for the fade envelope slot engine: add/tick commands against a local
// slot table predictor, with random gaps and register changes between phases.
// Depends on fes_pkg and the fade_envelope_slot_engine top level.
`timescale 1ns / 1ps
module tb_fade_envelope_slot_engine;
   import fes_pkg::*;

   logic         clock;
   logic         reset;
   logic         start;
   logic         busy;
   req_word_type req_word;
   logic         csr_we;
   logic [0:0]   csr_index;
   logic [31:0]  csr_wdata;
   logic         rsp_strobe;
   rsp_word_type rsp_word;

   fade_envelope_slot_engine u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_word(req_word), .csr_we(csr_we), .csr_index(csr_index),
      .csr_wdata(csr_wdata), .rsp_strobe(rsp_strobe), .rsp_word(rsp_word)
   );

   // local copy of the slot table and registers
   logic [31:0] merge_dist;
   logic [7:0]  hold_val;
   logic        tbl_on [SLOTS];
   logic [15:0] tbl_x [SLOTS];
   logic [15:0] tbl_y [SLOTS];
   logic [15:0] tbl_z [SLOTS];
   logic [15:0] tbl_rad [SLOTS];
   logic [3:0]  tbl_kind [SLOTS];
   logic [15:0] tbl_fin [SLOTS];
   logic [15:0] tbl_hold [SLOTS];
   logic [15:0] tbl_fout [SLOTS];
   logic [17:0] tbl_life [SLOTS];
   logic [7:0]  tbl_str [SLOTS];

   rsp_word_type expected_words[$];
   int errors = 0;

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
      errors++;
   endtask

   // clamp a ramp factor to the hold ceiling; zero length gives zero
   function automatic logic [7:0] ramp_factor(input logic [31:0] num,
                                              input logic [31:0] den);
      logic [63:0] f;
      if (den == 0) return 8'd0;
      f = ({32'd0, num} * 64'd256) / den;
      return (f > hold_val) ? hold_val : f[7:0];
   endfunction

   function automatic logic [33:0] sq_dist(input logic [15:0] a, input logic [15:0] b);
      int signed d;
      d = $signed(a) - $signed(b);
      if (d < 0) d = -d;
      return 34'(d) * 34'(d);
   endfunction

   // work out the words one command produces and advance the table
   task automatic predict_words(input req_word_type w);
      rsp_word_type r;
      logic [35:0] d;
      logic dup;
      int free_slot;
      int cnt;
      logic [31:0] t1, t2, lf;
      if (w.cmd == CMD_ADD) begin
         dup = 0;
         free_slot = -1;
         for (int i = 0; i < SLOTS; i++) begin
            if (tbl_on[i]) begin
               d = 36'(sq_dist(tbl_x[i], w.pos_x)) + 36'(sq_dist(tbl_y[i], w.pos_y))
                 + 36'(sq_dist(tbl_z[i], w.pos_z));
               if (d < {4'd0, merge_dist} && tbl_rad[i] >= w.radius) dup = 1;
            end else if (free_slot < 0) free_slot = i;
         end
         r = '0;
         r.last = 1;
         if (dup) r.status = ST_DUP;
         else if (free_slot < 0) r.status = ST_FULL;
         else begin
            tbl_x[free_slot] = w.pos_x;
            tbl_y[free_slot] = w.pos_y;
            tbl_z[free_slot] = w.pos_z;
            tbl_fin[free_slot] = w.fade_in;
            tbl_fout[free_slot] = w.fade_out;
            tbl_hold[free_slot] = w.hold_time;
            tbl_rad[free_slot] = w.radius;
            tbl_kind[free_slot] = w.fx_kind;
            tbl_life[free_slot] = 0;
            tbl_str[free_slot] = 0;
            tbl_on[free_slot] = 1;
            r.status = ST_OK;
            r.slot = free_slot[2:0];
         end
         expected_words.push_back(r);
      end else begin
         cnt = 0;
         for (int i = SLOTS - 1; i >= 0; i--) begin
            if (tbl_on[i]) begin
               t1 = 32'(tbl_fin[i]) + 32'(tbl_hold[i]);
               t2 = t1 + 32'(tbl_fout[i]);
               lf = 32'(tbl_life[i]) + 32'(w.elapsed);
               if (lf > 32'(LIFE_MAX)) lf = 32'(LIFE_MAX);
               tbl_life[i] = lf[17:0];
               if (lf <= 32'(tbl_fin[i])) tbl_str[i] = ramp_factor(lf, 32'(tbl_fin[i]));
               else if (lf <= t1) tbl_str[i] = hold_val;
               else if (lf < t2) tbl_str[i] = ramp_factor(t2 - lf, 32'(tbl_fout[i]));
               else tbl_on[i] = 0;
               if (tbl_on[i]) cnt++;
            end
            r = '0;
            r.report_kind = 1;
            r.slot = i[2:0];
            if (tbl_on[i]) begin
               r.out_x = tbl_x[i];
               r.out_y = tbl_y[i];
               r.out_z = tbl_z[i];
               r.strength = tbl_str[i];
               r.radius_whole = tbl_rad[i][15:4];
               r.out_kind = tbl_kind[i];
               r.live = 1;
            end
            if (i == 0) begin
               r.live_count = cnt[3:0];
               r.last = 1;
            end
            expected_words.push_back(r);
         end
      end
   endtask

   // compare every strobed word with the oldest expectation
   always @(posedge clock) begin
      rsp_word_type e;
      if (!reset && rsp_strobe) begin
         if (expected_words.size() == 0) begin
            report_mismatch("unexpected word", 0, 0);
         end else begin
            e = expected_words.pop_front();
            if (rsp_word.report_kind !== e.report_kind)
               report_mismatch("report_kind", rsp_word.report_kind, e.report_kind);
            if (rsp_word.status !== e.status)
               report_mismatch("status", rsp_word.status, e.status);
            if (rsp_word.slot !== e.slot) report_mismatch("slot", rsp_word.slot, e.slot);
            if (rsp_word.out_x !== e.out_x) report_mismatch("out_x", rsp_word.out_x, e.out_x);
            if (rsp_word.out_y !== e.out_y) report_mismatch("out_y", rsp_word.out_y, e.out_y);
            if (rsp_word.out_z !== e.out_z) report_mismatch("out_z", rsp_word.out_z, e.out_z);
            if (rsp_word.strength !== e.strength)
               report_mismatch("strength", rsp_word.strength, e.strength);
            if (rsp_word.radius_whole !== e.radius_whole)
               report_mismatch("radius_whole", rsp_word.radius_whole, e.radius_whole);
            if (rsp_word.out_kind !== e.out_kind)
               report_mismatch("out_kind", rsp_word.out_kind, e.out_kind);
            if (rsp_word.live !== e.live) report_mismatch("live", rsp_word.live, e.live);
            if (rsp_word.live_count !== e.live_count)
               report_mismatch("live_count", rsp_word.live_count, e.live_count);
            if (rsp_word.last !== e.last) report_mismatch("last", rsp_word.last, e.last);
         end
      end
   end

   // hold start until the block takes the word, then drop it
   task automatic send_word(input req_word_type w);
      int gap;
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 120) : $urandom_range(0, 3);
      if ($urandom_range(0, 3) == 0) gap = 0;
      repeat (gap + 1) @(posedge clock);
      start <= 1;
      req_word <= w;
      do @(posedge clock); while (busy);
      predict_words(w);
      start <= 0;
      req_word <= req_word_type'($urandom());
   endtask

   // wait for every expected word, then let the block settle
   task automatic drain();
      while (expected_words.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   task automatic write_reg(input logic [0:0] idx, input logic [31:0] val);
      @(posedge clock);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 0;
      if (idx == REG_MERGE) merge_dist = val;
      else hold_val = val[7:0];
   endtask

   function automatic req_word_type make_add(input logic [15:0] x, input logic [15:0] y,
         input logic [15:0] z, input logic [15:0] fin, input logic [15:0] hold,
         input logic [15:0] fout, input logic [15:0] rad, input logic [3:0] kind);
      req_word_type w;
      w = req_word_type'({$urandom(), $urandom(), $urandom(), $urandom(), $urandom()});
      w.cmd = CMD_ADD;
      w.pos_x = x; w.pos_y = y; w.pos_z = z;
      w.fade_in = fin; w.hold_time = hold; w.fade_out = fout;
      w.radius = rad; w.fx_kind = kind;
      return w;
   endfunction

   function automatic req_word_type make_tick(input logic [15:0] el);
      req_word_type w;
      w = req_word_type'({$urandom(), $urandom(), $urandom(), $urandom(), $urandom()});
      w.cmd = CMD_TICK;
      w.elapsed = el;
      return w;
   endfunction

   function automatic logic [15:0] rnd_time();
      case ($urandom_range(0, 5))
         0: return 16'd0;
         1: return 16'hFFFF;
         2: return 16'($urandom());
         default: return 16'($urandom_range(0, 60));
      endcase
   endfunction

   // extremes, duplicate before full, zero fade-in, saturation, expiry
   task automatic test_directed();
      send_word(make_tick(16'd5));
      send_word(make_add(16'h8000, 16'h7FFF, 16'h0000, 16'd0, 16'd4, 16'd8, 16'hFFFF, 4'hF));
      send_word(make_add(16'h8001, 16'h7FFF, 16'h0000, 16'd1, 16'd1, 16'd1, 16'h0010,
                         4'h0));
      send_word(make_add(16'h7FFF, 16'h8000, 16'hFFFF, 16'd10, 16'd0, 16'd0, 16'h0000, 4'h5));
      send_word(make_add(16'h7FFF, 16'h8000, 16'hFFFF, 16'd1, 16'd1, 16'd1, 16'h0001,
                         4'h1));
      send_word(make_add(16'h1000, 16'h1000, 16'h1000, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                         16'h0100, 4'hA));
      send_word(make_add(16'h2000, 16'h2000, 16'h2000, 16'd8, 16'd2, 16'd8, 16'h0020, 4'h3));
      for (int i = 0; i < 3; i++)
         send_word(make_add(16'(i * 1000), 16'h0, 16'h0, 16'd4, 16'd4, 16'd4, 16'h10, 4'h7));
      send_word(make_add(16'h4000, 16'h0, 16'h0, 16'd1, 16'd1, 16'd1, 16'd1, 4'h2));
      send_word(make_add(16'h1000, 16'h1000, 16'h1000, 16'd1, 16'd1, 16'd1, 16'd0, 4'h9));
      for (int t = 0; t < 6; t++) send_word(make_tick(16'd3));
      send_word(make_tick(16'hFFFF));
      send_word(make_tick(16'hFFFF));
      send_word(make_tick(16'hFFFF));
      send_word(make_tick(16'hFFFF));
      send_word(make_tick(16'hFFFF));
      send_word(make_tick(16'd0));
      drain();
   endtask

   // mostly adds near a few centers and short ticks, so the table fills and drains
   task automatic test_random(input int count);
      logic [15:0] cx;
      req_word_type w;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 2) == 0) begin
            w = make_tick($urandom_range(0, 4) == 0 ? 16'($urandom())
                                                   : 16'($urandom_range(0, 20)));
         end else begin
            cx = 16'($urandom_range(0, 3) * 16'h0400);
            w = make_add(cx + 16'($urandom_range(0, 40)), 16'($urandom_range(0, 40)),
                         ($urandom_range(0, 7) == 0) ? 16'($urandom())
                                                     : 16'($urandom_range(0, 40)),
                         rnd_time(), rnd_time(), rnd_time(),
                         ($urandom_range(0, 4) == 0) ? 16'($urandom())
                                                     : 16'($urandom_range(0, 64)),
                         4'($urandom()));
            if ($urandom_range(0, 7) == 0) begin
               w.pos_x = 16'($urandom());
               w.pos_y = 16'($urandom());
            end
         end
         send_word(w);
         if (n % 50 == 49) drain();
      end
      drain();
   endtask

   initial begin
      clock = 0;
      reset = 1;
      start = 0;
      req_word = '0;
      csr_we = 0;
      csr_index = REG_MERGE;
      csr_wdata = '0;
      merge_dist = 32'd1024;
      hold_val = 8'd253;
      for (int i = 0; i < SLOTS; i++) begin
         tbl_on[i] = 0; tbl_x[i] = 0; tbl_y[i] = 0; tbl_z[i] = 0; tbl_rad[i] = 0;
         tbl_kind[i] = 0; tbl_fin[i] = 0; tbl_hold[i] = 0; tbl_fout[i] = 0;
         tbl_life[i] = 0; tbl_str[i] = 0;
      end
      repeat (8) @(posedge clock);
      reset <= 0;
      repeat (2) @(posedge clock);
      test_directed();
      write_reg(REG_MERGE, 32'hFFFFFFFF);
      write_reg(REG_HOLD, 32'd255);
      test_random(70);
      write_reg(REG_MERGE, 32'd0);
      write_reg(REG_HOLD, 32'd0);
      test_random(70);
      write_reg(REG_MERGE, 32'd40000);
      write_reg(REG_HOLD, 32'd128);
      test_random(100);
      write_reg(REG_MERGE, $urandom());
      write_reg(REG_HOLD, {24'd0, 8'($urandom())});
      test_random(100);
      if (errors == 0) begin
         $display("PASS fade_envelope_slot_engine");
      end else begin
         $display("FAIL fade_envelope_slot_engine");
      end
      $finish;
   end

   // end the run if the block hangs
   initial begin
      #40ms;
      $display("FAIL fade_envelope_slot_engine");
      $finish;
   end
endmodule

// ----- fade_envelope_slot_engine.f -----
+incdir+rtl
rtl/fes_pkg.sv
rtl/fes_divider.sv
rtl/fes_datapath.sv
rtl/fes_control.sv
rtl/fade_envelope_slot_engine.sv
tb/tb_fade_envelope_slot_engine.sv
